// ===== src/sndag_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sndag_pkg;

  // Table dimensions
  localparam int MAX_DIMS     = 8;
  localparam int MAX_OPERANDS = 4;

  // Index and count widths derived from the table dimensions
  localparam int DIM_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int OP_W   = (MAX_OPERANDS > 1) ? $clog2(MAX_OPERANDS) : 1;
  localparam int DCNT_W = $clog2(MAX_DIMS + 1);
  localparam int OCNT_W = $clog2(MAX_OPERANDS + 1);

  // Field widths
  localparam int WORD_W  = 32;
  localparam int MODE_W  = 3;
  localparam int DIMI_W  = 3;
  localparam int OPI_W   = 2;
  localparam int INNER_W = 4;
  localparam int OPO_W   = 2;

  // Stream and configuration port widths
  localparam int S_TDATA_W  = 48;
  localparam int S_TUSER_W  = MODE_W;
  localparam int M_TDATA_W  = WORD_W;
  localparam int M_TUSER_W  = OPO_W;
  localparam int DCFG_W     = 4;
  localparam int OCFG_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // Bit positions of the request fields in s_tdata
  localparam int TD_DIM_LO   = 0;
  localparam int TD_OPI_LO   = TD_DIM_LO + DIMI_W;
  localparam int TD_VAL_LO   = TD_OPI_LO + OPI_W;
  localparam int TD_INNER_LO = TD_VAL_LO + WORD_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OPERAND_COUNT = 2'd1;

  // Command queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Request mode codes
  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD_SIZE   = 3'd0,
    MODE_LOAD_STRIDE = 3'd1,
    MODE_LOAD_BASE   = 3'd2,
    MODE_START       = 3'd3,
    MODE_STEP        = 3'd4
  } mode_t;

  // Decoded command kinds
  typedef enum logic [2:0] {
    CMD_SIZE,
    CMD_STRIDE,
    CMD_BASE,
    CMD_START,
    CMD_STEP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                kind;
    logic [DIMI_W-1:0]        dim;
    logic [OPI_W-1:0]         opnd;
    logic [WORD_W-1:0]        value;
    logic [INNER_W-1:0]       inner;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // Execution sequencer states
  typedef enum logic [2:0] {
    B_IDLE,
    B_SCAN,
    B_MUL,
    B_ADD,
    B_OUT
  } back_state_t;

endpackage

`default_nettype wire

// ===== src/sndag_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sndag_front (
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [sndag_pkg::S_TDATA_W-1:0] s_tdata,
  input  wire logic [sndag_pkg::S_TUSER_W-1:0] s_tuser,
  input  wire sndag_pkg::q_status_t           q_status,
  output logic                                push,
  output sndag_pkg::cmd_t                     cmd
);
  import sndag_pkg::*;

  logic accept;
  logic keep;

  // Requests are taken whenever the queue has room
  assign s_tready = !q_status.full;
  assign accept   = s_tvalid && s_tready;
  assign push     = accept && keep;

  // Unpack the request fields and classify; unknown modes and out-of-range loads are dropped
  always_comb begin
    cmd.dim   = s_tdata[TD_DIM_LO +: DIMI_W];
    cmd.opnd  = s_tdata[TD_OPI_LO +: OPI_W];
    cmd.value = s_tdata[TD_VAL_LO +: WORD_W];
    cmd.inner = s_tdata[TD_INNER_LO +: INNER_W];
    cmd.kind  = CMD_START;
    keep      = 1'b0;
    unique case (mode_t'(s_tuser))
      MODE_LOAD_SIZE: begin
        cmd.kind = CMD_SIZE;
        keep     = 32'(s_tdata[TD_DIM_LO +: DIMI_W]) < MAX_DIMS;
      end
      MODE_LOAD_STRIDE: begin
        cmd.kind = CMD_STRIDE;
        keep     = (32'(s_tdata[TD_DIM_LO +: DIMI_W]) < MAX_DIMS) &&
                   (32'(s_tdata[TD_OPI_LO +: OPI_W]) < MAX_OPERANDS);
      end
      MODE_LOAD_BASE: begin
        cmd.kind = CMD_BASE;
        keep     = 32'(s_tdata[TD_OPI_LO +: OPI_W]) < MAX_OPERANDS;
      end
      MODE_START: begin
        cmd.kind = CMD_START;
        keep     = 1'b1;
      end
      MODE_STEP: begin
        cmd.kind = CMD_STEP;
        keep     = 1'b1;
      end
      default: begin
        cmd.kind = CMD_START;
        keep     = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/sndag_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sndag_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire sndag_pkg::cmd_t cmd_in,
  input  wire logic            pop,
  output sndag_pkg::cmd_t      cmd_out,
  output sndag_pkg::q_status_t status
);
  import sndag_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign status.empty = (count == '0);
  assign status.full  = (32'(count) == QUEUE_DEPTH);
  assign cmd_out      = entries[rd_ptr];

  // Pointer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == QUEUE_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == QUEUE_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

// ===== src/sndag_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sndag_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [sndag_pkg::DCFG_W-1:0]    dim_count,
  input  wire logic [sndag_pkg::OCFG_W-1:0]    operand_count,
  input  wire sndag_pkg::q_status_t            q_status,
  input  wire sndag_pkg::cmd_t                 qcmd,
  output logic                                 pop,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [sndag_pkg::M_TDATA_W-1:0]      m_tdata,
  output logic [sndag_pkg::M_TUSER_W-1:0]      m_tuser,
  output logic                                 m_tlast
);
  import sndag_pkg::*;

  // Tables
  logic [WORD_W-1:0] counters [MAX_DIMS];
  logic [WORD_W-1:0] sizes    [MAX_DIMS];
  logic [WORD_W-1:0] strides  [MAX_OPERANDS][MAX_DIMS];
  logic [WORD_W-1:0] bases    [MAX_OPERANDS];

  back_state_t       state;
  back_state_t       state_next;
  logic [DCNT_W-1:0] d;
  logic [DCNT_W-1:0] first;
  logic [OCNT_W-1:0] op;
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] prod;

  logic [DCNT_W-1:0] nd;
  logic [OCNT_W-1:0] nops;
  logic [DIM_W-1:0]  d_idx;
  logic [OP_W-1:0]   op_idx;
  logic [WORD_W:0]   cnt_inc;
  logic [WORD_W:0]   size_ext;
  logic              wraps;
  logic              d_last;
  logic              op_last;
  logic              out_free;
  logic              out_load;
  logic              step_skip;

  // Effective counts, clamped to the table sizes
  assign nd   = (32'(dim_count) > MAX_DIMS) ? DCNT_W'(MAX_DIMS) : DCNT_W'(dim_count);
  assign nops = (32'(operand_count) > MAX_OPERANDS) ? OCNT_W'(MAX_OPERANDS)
                                                    : OCNT_W'(operand_count);

  assign d_idx   = DIM_W'(d);
  assign op_idx  = OP_W'(op);
  assign d_last  = (32'(d) + 1 >= 32'(nd));
  assign op_last = (32'(op) + 1 == 32'(nops));

  // Counter increment against a signed size
  assign cnt_inc  = {1'b0, counters[d_idx]} + 33'd1;
  assign size_ext = {sizes[d_idx][WORD_W-1], sizes[d_idx]};
  assign wraps    = $signed(cnt_inc) >= $signed(size_ext);

  assign step_skip = (32'(qcmd.inner) >= 32'(nd));
  assign out_free  = !m_tvalid || m_tready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (!q_status.empty) begin
          if (qcmd.kind == CMD_START) begin
            if (nops == '0) begin
              state_next = B_IDLE;
            end else if (nd == '0) begin
              state_next = B_OUT;
            end else begin
              state_next = B_MUL;
            end
          end else if (qcmd.kind == CMD_STEP) begin
            state_next = step_skip ? B_IDLE : B_SCAN;
          end
        end
      end
      B_SCAN: begin
        if (wraps) begin
          state_next = d_last ? B_IDLE : B_SCAN;
        end else begin
          state_next = (nops == '0) ? B_IDLE : B_MUL;
        end
      end
      B_MUL: begin
        state_next = B_ADD;
      end
      B_ADD: begin
        state_next = d_last ? B_OUT : B_MUL;
      end
      B_OUT: begin
        if (out_free) begin
          if (op_last) begin
            state_next = B_IDLE;
          end else begin
            state_next = (32'(first) >= 32'(nd)) ? B_OUT : B_MUL;
          end
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    pop      = 1'b0;
    out_load = 1'b0;
    unique case (state)
      B_IDLE:  pop      = !q_status.empty;
      B_OUT:   out_load = out_free;
      default: begin
        pop      = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  // Control registers and tables with reset values
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      m_tvalid <= 1'b0;
      for (int i = 0; i < MAX_DIMS; i++) begin
        counters[i] <= '0;
        sizes[i]    <= WORD_W'(1);
      end
      for (int p = 0; p < MAX_OPERANDS; p++) begin
        bases[p] <= '0;
        for (int i = 0; i < MAX_DIMS; i++) begin
          strides[p][i] <= '0;
        end
      end
    end else begin
      state <= state_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      // Table writes and odometer
      if (pop) begin
        case (qcmd.kind)
          CMD_SIZE:   sizes[DIM_W'(qcmd.dim)] <= qcmd.value;
          CMD_STRIDE: strides[OP_W'(qcmd.opnd)][DIM_W'(qcmd.dim)] <= qcmd.value;
          CMD_BASE:   bases[OP_W'(qcmd.opnd)] <= qcmd.value;
          CMD_START: begin
            for (int i = 0; i < MAX_DIMS; i++) begin
              counters[i] <= '0;
            end
          end
          default: ;
        endcase
      end
      if (state == B_SCAN) begin
        counters[d_idx] <= wraps ? '0 : cnt_inc[WORD_W-1:0];
      end
    end
  end

  // Datapath: dimension walk, multiply and accumulate, output register
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (qcmd.kind == CMD_STEP) begin
          d     <= DCNT_W'(qcmd.inner);
          first <= DCNT_W'(qcmd.inner);
        end else begin
          d     <= '0;
          first <= '0;
        end
        op  <= '0;
        acc <= bases[0];
      end
      B_SCAN: begin
        if (wraps) begin
          d <= d + 1'b1;
        end else begin
          d   <= first;
          op  <= '0;
          acc <= bases[0];
        end
      end
      B_MUL: begin
        prod <= strides[op_idx][d_idx] * counters[d_idx];
      end
      B_ADD: begin
        acc <= acc + prod;
        d   <= d + 1'b1;
      end
      B_OUT: begin
        if (out_free) begin
          m_tdata <= acc;
          m_tuser <= OPO_W'(op);
          m_tlast <= op_last;
          d       <= first;
          op      <= op + 1'b1;
          if (!op_last) begin
            acc <= bases[OP_W'(op + 1'b1)];
          end
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/strided_nd_address_generator_unit.sv =====
// Strided N-dimensional address generator.
//
// s_* carries requests: s_tuser is the mode (load size, load stride, load
// base, start, step); s_tdata carries dimension, operand, load value and the
// inner dimension count of a step. m_* returns one offset per operand, in
// operand order, with m_tuser the operand and m_tlast on the last operand.
// cfg_* writes dim_count (index 0) and operand_count (index 1); it is always
// ready and must only be used while the block is idle.
// Requests pass a two-entry command queue to a sequencer that executes them
// one at a time. A load writes its table entry as it leaves the queue. A
// start clears the counters and computes the offset of every operand; a step
// advances the odometer from its inner dimension and, unless it wraps past the
// last dimension, recomputes the offsets. Each stride product goes through a
// single shared 32-bit multiplier and accumulator.
// Reset clears the counters, strides and bases, sets every size to one,
// dim_count to 0 and operand_count to 1. A stalled receiver holds the output
// register; the sequencer waits and the queue fills, then s_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module strided_nd_address_generator_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // [2:0] dim_index, [4:3] operand_index, [36:5] load_value,
  // [40:37] inner_dims, [47:41] zero
  input  wire logic [sndag_pkg::S_TDATA_W-1:0]  s_tdata,
  // [2:0] mode
  input  wire logic [sndag_pkg::S_TUSER_W-1:0]  s_tuser,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // [31:0] offset
  output logic [sndag_pkg::M_TDATA_W-1:0]       m_tdata,
  // [1:0] operand
  output logic [sndag_pkg::M_TUSER_W-1:0]       m_tuser,
  output logic                                  m_tlast,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [sndag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sndag_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sndag_pkg::*;

  logic [DCFG_W-1:0] dim_count;
  logic [OCFG_W-1:0] operand_count;
  q_status_t         q_status;
  cmd_t              front_cmd;
  cmd_t              queue_cmd;
  logic              push;
  logic              pop;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_count     <= '0;
      operand_count <= OCFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DIM_COUNT:     dim_count     <= cfg_data[DCFG_W-1:0];
        CFG_OPERAND_COUNT: operand_count <= cfg_data[OCFG_W-1:0];
        default: ;
      endcase
    end
  end

  sndag_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_status (q_status),
    .push     (push),
    .cmd      (front_cmd)
  );

  sndag_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .cmd_in  (front_cmd),
    .pop     (pop),
    .cmd_out (queue_cmd),
    .status  (q_status)
  );

  sndag_back u_back (
    .clk           (clk),
    .rst           (rst),
    .dim_count     (dim_count),
    .operand_count (operand_count),
    .q_status      (q_status),
    .qcmd          (queue_cmd),
    .pop           (pop),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast)
  );

endmodule

`default_nettype wire
